@@ design/sot_pkg.sv @@
// ----------------------------------------------------------------------------
// sot_pkg
// Shared codes and types for the shape overlap test pipeline.
// ----------------------------------------------------------------------------
package sot_pkg;

    // Shape kind codes carried in tuser.
    localparam logic KIND_RECT   = 1'b0;
    localparam logic KIND_CIRCLE = 1'b1;

    // Output beat width: one flag padded to a whole byte.
    localparam int M_TDATA_W = 8;

    // Per-item decision flags that ride along the pipeline.
    typedef struct packed {
        logic rect_pair;  // both shapes are rectangles
        logic span_hit;   // strict interval overlap on both axes
    } sot_ctl_t;

endpackage

@@ design/sot_axis_dist.sv @@
// ----------------------------------------------------------------------------
// sot_axis_dist
// One axis of the overlap test: strict interval overlap for two rectangles,
// and the clamped distance from a circle centre to the other shape.
// ----------------------------------------------------------------------------
module sot_axis_dist #(
    parameter int COORD_BITS = 16
) (
    input  logic                         a_kind,
    input  logic signed [COORD_BITS-1:0] a_pos,
    input  logic        [COORD_BITS-2:0] a_len,
    input  logic                         b_kind,
    input  logic signed [COORD_BITS-1:0] b_pos,
    input  logic        [COORD_BITS-2:0] b_len,
    output logic                         span_hit,
    output logic        [COORD_BITS-1:0] gap
);
    import sot_pkg::*;

    localparam int EW = COORD_BITS + 2;

    logic signed [EW-1:0] a_lo;
    logic signed [EW-1:0] a_hi;
    logic signed [EW-1:0] b_lo;
    logic signed [EW-1:0] b_hi;
    logic signed [EW-1:0] rect_lo;
    logic signed [EW-1:0] rect_hi;
    logic signed [EW-1:0] ctr;
    logic signed [EW-1:0] lo_gap;
    logic signed [EW-1:0] hi_gap;

    assign a_lo = EW'(a_pos);
    assign b_lo = EW'(b_pos);
    assign a_hi = a_lo + $signed({3'b000, a_len});
    assign b_hi = b_lo + $signed({3'b000, b_len});

    assign span_hit = (a_lo < b_hi) && (a_hi > b_lo);

    // A circle against a circle is treated as a circle against a point
    // interval at the other centre, which gives the absolute difference.
    always_comb begin
        if (a_kind == KIND_RECT && b_kind == KIND_CIRCLE) begin
            rect_lo = a_lo;
            rect_hi = a_hi;
            ctr     = b_lo;
        end else if (b_kind == KIND_RECT) begin
            rect_lo = b_lo;
            rect_hi = b_hi;
            ctr     = a_lo;
        end else begin
            rect_lo = b_lo;
            rect_hi = b_lo;
            ctr     = a_lo;
        end
    end

    assign lo_gap = rect_lo - ctr;
    assign hi_gap = ctr - rect_hi;

    always_comb begin
        if (lo_gap > 0) begin
            gap = lo_gap[COORD_BITS-1:0];
        end else if (hi_gap > 0) begin
            gap = hi_gap[COORD_BITS-1:0];
        end else begin
            gap = '0;
        end
    end

endmodule

@@ design/shape_overlap_test.sv @@
// ----------------------------------------------------------------------------
// shape_overlap_test
// Overlap test for a pair of rectangles and circles per beat.
// ----------------------------------------------------------------------------
// Each input beat carries two shapes and yields one result beat telling
// whether they overlap. The block takes one beat per clock while the output
// side does not stall, and passes each beat through three registered stages:
// stage one forms the per-axis gaps and the radius, stage two squares them,
// stage three adds and compares into the output register. Each stage moves
// on its own, so bubbles close up and a stall on the output holds the
// pipeline without loss.
module shape_overlap_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // tdata from bit 0: first_x, first_y, first_size, first_height,
    // second_x, second_y, second_size, second_height, zero padding.
    input  logic [((8*COORD_BITS-4+7)/8)*8-1:0]      s_tdata,
    // tuser from bit 0: first_kind, second_kind.
    input  logic [1:0]                               s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // tdata from bit 0: overlapping, zero padding.
    output logic [sot_pkg::M_TDATA_W-1:0]            m_tdata
);
    import sot_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C;
    localparam int O_AX  = 0;
    localparam int O_AY  = C;
    localparam int O_AS  = 2 * C;
    localparam int O_AH  = 3 * C - 1;
    localparam int O_BX  = 4 * C - 2;
    localparam int O_BY  = 5 * C - 2;
    localparam int O_BS  = 6 * C - 2;
    localparam int O_BH  = 7 * C - 3;

    logic                first_kind;
    logic                second_kind;
    logic signed [C-1:0] first_x;
    logic signed [C-1:0] first_y;
    logic        [C-2:0] first_size;
    logic        [C-2:0] first_height;
    logic signed [C-1:0] second_x;
    logic signed [C-1:0] second_y;
    logic        [C-2:0] second_size;
    logic        [C-2:0] second_height;

    assign first_kind    = s_tuser[0];
    assign second_kind   = s_tuser[1];
    assign first_x       = s_tdata[O_AX +: C];
    assign first_y       = s_tdata[O_AY +: C];
    assign first_size    = s_tdata[O_AS +: C-1];
    assign first_height  = s_tdata[O_AH +: C-1];
    assign second_x      = s_tdata[O_BX +: C];
    assign second_y      = s_tdata[O_BY +: C];
    assign second_size   = s_tdata[O_BS +: C-1];
    assign second_height = s_tdata[O_BH +: C-1];

    // Stage one: per-axis gaps and radius.
    logic         span_x;
    logic         span_y;
    logic [C-1:0] dist_x;
    logic [C-1:0] dist_y;
    logic [C-1:0] radius;
    sot_ctl_t     ctl1;

    sot_axis_dist #(.COORD_BITS(C)) u_axis_x (
        .a_kind   (first_kind),
        .a_pos    (first_x),
        .a_len    (first_size),
        .b_kind   (second_kind),
        .b_pos    (second_x),
        .b_len    (second_size),
        .span_hit (span_x),
        .gap      (dist_x)
    );

    sot_axis_dist #(.COORD_BITS(C)) u_axis_y (
        .a_kind   (first_kind),
        .a_pos    (first_y),
        .a_len    (first_height),
        .b_kind   (second_kind),
        .b_pos    (second_y),
        .b_len    (second_height),
        .span_hit (span_y),
        .gap      (dist_y)
    );

    always_comb begin
        if (first_kind == KIND_CIRCLE && second_kind == KIND_CIRCLE) begin
            radius = C'(first_size) + C'(second_size);
        end else if (first_kind == KIND_CIRCLE) begin
            radius = C'(first_size);
        end else begin
            radius = C'(second_size);
        end
        ctl1.rect_pair = (first_kind == KIND_RECT) && (second_kind == KIND_RECT);
        ctl1.span_hit  = span_x && span_y;
    end

    logic            v1_reg, v2_reg, v3_reg;
    logic            rdy1, rdy2, rdy3;
    logic [C-1:0]    dx1_reg, dy1_reg, r1_reg;
    sot_ctl_t        ctl1_reg, ctl2_reg;
    logic [SQ_W-1:0] dx2_reg, dy2_reg, r2_reg;
    logic [SQ_W:0]   dsum;
    logic            hit;
    logic            hit_reg;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            dx1_reg  <= dist_x;
            dy1_reg  <= dist_y;
            r1_reg   <= radius;
            ctl1_reg <= ctl1;
        end
        if (rdy2 && v1_reg) begin
            dx2_reg  <= SQ_W'(dx1_reg) * SQ_W'(dx1_reg);
            dy2_reg  <= SQ_W'(dy1_reg) * SQ_W'(dy1_reg);
            r2_reg   <= SQ_W'(r1_reg) * SQ_W'(r1_reg);
            ctl2_reg <= ctl1_reg;
        end
        if (rdy3 && v2_reg) begin
            hit_reg <= hit;
        end
    end

    // Stage three: rectangles by span flag, else dist^2 <= radius^2.
    assign dsum = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign hit  = ctl2_reg.rect_pair ? ctl2_reg.span_hit : (dsum <= {1'b0, r2_reg});

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, hit_reg};

endmodule

@@ design/sot_checker.sv @@
// ----------------------------------------------------------------------------
// sot_checker
// Port-level checks on the shape overlap test, bound to the top level.
// ----------------------------------------------------------------------------
module sot_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_tdata,
    input logic [1:0]                          s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [sot_pkg::M_TDATA_W-1:0]       m_tdata
);
    import sot_pkg::*;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // A waiting input beat holds its value until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("stalled input beat changed");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // With the output draining, the input never backs up.
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled while output drains");

    // Only the flag bit may be set in a result beat.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
        else $error("padding bits set in result beat");

endmodule

bind shape_overlap_test sot_checker #(.COORD_BITS(COORD_BITS)) u_sot_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
